// ----- src/encoder_angle_tracker_assert.svh -----
// assertion macros shared by the checker
`ifndef ENCODER_ANGLE_TRACKER_ASSERT_SVH
`define ENCODER_ANGLE_TRACKER_ASSERT_SVH

// same-cycle implication
`define EAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eat: same-cycle check failed");

// next-cycle implication
`define EAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eat: next-cycle check failed");

`endif

// ----- src/eat_pkg.sv -----
`default_nettype none
package eat_pkg;

  localparam int RawBitsDef  = 14;
  localparam int TurnBitsDef = 48;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam int DvsW     = 17;
  localparam int ModN     = 17;

  localparam logic [27:0] VelScale = 28'd256000000;
  localparam logic [16:0] AlphaOne = 17'd65536;

  localparam logic [13:0] RstOffset = 14'd0;
  localparam logic [14:0] RstCpr    = 15'd16384;
  localparam logic [14:0] RstMaxD   = 15'd8192;
  localparam logic [15:0] RstStale  = 16'd8;
  localparam logic [15:0] RstGStale = 16'd8;
  localparam logic [16:0] RstAlpha  = 17'd6554;
  localparam logic [6:0]  RstPoles  = 7'd7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIR    = 3'd0,
    REG_OFFSET = 3'd1,
    REG_CPR    = 3'd2,
    REG_MAXD   = 3'd3,
    REG_STALE  = 3'd4,
    REG_GSTALE = 3'd5,
    REG_ALPHA  = 3'd6,
    REG_POLES  = 3'd7
  } eat_reg_e;

  typedef struct packed {
    logic capture;
    logic upd_invalid;
    logic div_mod;
    logic pos_fix;
    logic upd_base;
    logic upd_glitch;
    logic upd_accept;
    logic vmul;
    logic div_vel;
    logic raw_store;
    logic filt_mul;
    logic filt_upd;
    logic div_elec;
    logic elec_store;
    logic out_load;
  } eat_cmd_t;

  typedef struct packed {
    logic invalid;
    logic have_base;
    logic glitch;
    logic elapsed_zero;
    logic div_busy;
    logic out_free;
  } eat_sts_t;

endpackage
`default_nettype wire

// ----- src/encoder_angle_tracker.sv -----
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_stall_o    raw_code_i, raw_ok_i, elapsed_us_i
// out      source     out_valid_o / out_stall_i  position, electrical, multiturn, velocity,
//                                                sample_valid, stale, glitch_total
// cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one beat at a time; a shared one-bit-a-cycle divider sets the latency
// invalid sample: electrical divide only
// accepted sample with time: modulo, velocity and electrical divides in turn
// a finished beat sits in the output register while the next input is taken
// asynchronous active-low reset clears all tracker state and the registers to defaults
`default_nettype none
module encoder_angle_tracker #(
  parameter int RAW_BITS  = eat_pkg::RawBitsDef,
  parameter int TURN_BITS = eat_pkg::TurnBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [15:0]                   raw_code_i,
  input  wire logic                          raw_ok_i,
  input  wire logic [15:0]                   elapsed_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [RAW_BITS-1:0]                position_counts_o,
  output logic [RAW_BITS-1:0]                electrical_counts_o,
  output logic signed [47:0]                 multiturn_counts_o,
  output logic signed [31:0]                 velocity_o,
  output logic                               sample_valid_o,
  output logic                               stale_o,
  output logic [31:0]                        glitch_total_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [eat_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [eat_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import eat_pkg::*;

  eat_cmd_t cmd;
  eat_sts_t sts;

  eat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eat_dp #(.RAW_BITS(RAW_BITS), .TURN_BITS(TURN_BITS)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .raw_code_i          (raw_code_i),
    .raw_ok_i            (raw_ok_i),
    .elapsed_us_i        (elapsed_us_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .position_counts_o   (position_counts_o),
    .electrical_counts_o (electrical_counts_o),
    .multiturn_counts_o  (multiturn_counts_o),
    .velocity_o          (velocity_o),
    .sample_valid_o      (sample_valid_o),
    .stale_o             (stale_o),
    .glitch_total_o      (glitch_total_o)
  );

endmodule
`default_nettype wire

// ----- src/eat_div.sv -----
`default_nettype none
module eat_div #(
  parameter int DivW = eat_pkg::RawBitsDef + 30,
  parameter int DvsW = eat_pkg::DvsW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DivW-1:0]               dividend_i,
  input  wire logic [$clog2(DivW+1)-1:0]     count_i,
  input  wire logic [DvsW-1:0]               divisor_i,
  output logic                               busy_o,
  output logic [DivW-1:0]                    quo_o,
  output logic [DvsW-1:0]                    rem_o
);
  localparam int CntW = $clog2(DivW+1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   shifted, trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    trial   = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = count_i;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DvsW]) begin
        rem_d = trial[DvsW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DvsW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- src/eat_dp.sv -----
`default_nettype none
module eat_dp #(
  parameter int RAW_BITS  = eat_pkg::RawBitsDef,
  parameter int TURN_BITS = eat_pkg::TurnBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire eat_pkg::eat_cmd_t             cmd_i,
  output eat_pkg::eat_sts_t                  sts_o,
  input  wire logic [15:0]                   raw_code_i,
  input  wire logic                          raw_ok_i,
  input  wire logic [15:0]                   elapsed_us_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [eat_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [eat_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [RAW_BITS-1:0]                position_counts_o,
  output logic [RAW_BITS-1:0]                electrical_counts_o,
  output logic signed [47:0]                 multiturn_counts_o,
  output logic signed [31:0]                 velocity_o,
  output logic                               sample_valid_o,
  output logic                               stale_o,
  output logic [31:0]                        glitch_total_o
);
  import eat_pkg::*;

  localparam int R     = RAW_BITS;
  localparam int DivW  = RAW_BITS + 30;
  localparam int CntW  = $clog2(DivW+1);
  localparam int ElecN = RAW_BITS + 7;
  localparam logic [16:0] RawMax = 17'((1 << RAW_BITS) - 1);
  localparam logic [R:0]  CprMax = {1'b1, {R{1'b0}}};

  // configuration
  logic        dir_q;
  logic [13:0] off_q;
  logic [14:0] cpr_q;
  logic [14:0] maxd_q;
  logic [15:0] slim_q, glim_q;
  logic [16:0] alpha_q;
  logic [6:0]  poles_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      off_q   <= RstOffset;
      cpr_q   <= RstCpr;
      maxd_q  <= RstMaxD;
      slim_q  <= RstStale;
      glim_q  <= RstGStale;
      alpha_q <= RstAlpha;
      poles_q <= RstPoles;
    end else if (cfg_we_i) begin
      case (eat_reg_e'(cfg_idx_i))
        REG_DIR:    dir_q   <= cfg_wdata_i[0];
        REG_OFFSET: off_q   <= cfg_wdata_i[13:0];
        REG_CPR:    cpr_q   <= cfg_wdata_i[14:0];
        REG_MAXD:   maxd_q  <= cfg_wdata_i[14:0];
        REG_STALE:  slim_q  <= cfg_wdata_i[15:0];
        REG_GSTALE: glim_q  <= cfg_wdata_i[15:0];
        REG_ALPHA:  alpha_q <= cfg_wdata_i;
        REG_POLES:  poles_q <= cfg_wdata_i[6:0];
        default:    dir_q   <= dir_q;
      endcase
    end
  end

  // captured beat
  logic [15:0] raw_q, elapsed_q;
  logic        ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q     <= raw_code_i;
      ok_q      <= raw_ok_i;
      elapsed_q <= elapsed_us_i;
    end
  end

  // effective modulus
  logic [R:0] cpr_eff;
  always_comb begin
    if (cpr_q == 15'd0) begin
      cpr_eff = (R+1)'(1);
    end else if ({2'b0, cpr_q} > 17'(CprMax)) begin
      cpr_eff = CprMax;
    end else begin
      cpr_eff = (R+1)'(cpr_q);
    end
  end

  // tracker state
  logic                   have_base_q, valid_q, stale_q;
  logic [R-1:0]           last_q;
  logic [TURN_BITS-1:0]   acc_q;
  logic signed [31:0]     vel_q;
  logic [15:0]            inv_run_q, g_run_q;
  logic [31:0]            g_cnt_q;

  // working registers
  logic [R-1:0]           pos_q, elec_q;
  logic                   neg_q, dneg_q;
  logic [R:0]             dmag_q;
  logic [DivW-1:0]        prod_q;
  logic signed [31:0]     rawv_q;
  logic signed [50:0]     mul_q;

  // divider
  logic                   div_start, div_busy;
  logic [DivW-1:0]        div_dividend, div_quo;
  logic [CntW-1:0]        div_count;
  logic [DvsW-1:0]        div_divisor, div_rem;

  eat_div #(.DivW(DivW), .DvsW(DvsW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .count_i    (div_count),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // offset, direction and magnitude for the wrap
  logic signed [17:0] off_diff, pos_s;
  logic [16:0]        pos_mag;
  logic [R+6:0]       elec_prod;
  always_comb begin
    off_diff  = $signed({2'b0, raw_q}) - $signed({4'b0, off_q});
    pos_s     = dir_q ? -off_diff : off_diff;
    pos_mag   = pos_s[17] ? 17'(-pos_s) : pos_s[16:0];
    elec_prod = (R+7)'(last_q) * (R+7)'(poles_q);
  end

  always_comb begin
    div_start    = cmd_i.div_mod | cmd_i.div_vel | cmd_i.div_elec;
    div_dividend = DivW'(pos_mag) << (DivW - ModN);
    div_count    = CntW'(ModN);
    div_divisor  = DvsW'(cpr_eff);
    if (cmd_i.div_vel) begin
      div_dividend = prod_q;
      div_count    = CntW'(DivW);
      div_divisor  = DvsW'(elapsed_q);
    end else if (cmd_i.div_elec) begin
      div_dividend = DivW'(elec_prod) << (DivW - ElecN);
      div_count    = CntW'(ElecN);
    end
  end

  // floor modulo fix-up
  logic [16:0] pos_fixed;
  assign pos_fixed = (neg_q && div_rem != '0) ? (17'(cpr_eff) - 17'(div_rem))
                                              : 17'(div_rem);

  // shortest delta
  logic signed [R+1:0] dd, d_adj;
  logic signed [R+2:0] d2, cpr_s;
  logic [R:0]          dmag;
  logic                glitch;
  always_comb begin
    dd    = $signed({2'b0, pos_q}) - $signed({2'b0, last_q});
    d2    = {dd, 1'b0};
    cpr_s = $signed({2'b0, cpr_eff});
    d_adj = dd;
    if (d2 > cpr_s) begin
      d_adj = dd - $signed({1'b0, cpr_eff});
    end else if (d2 < -cpr_s) begin
      d_adj = dd + $signed({1'b0, cpr_eff});
    end
    dmag   = d_adj[R+1] ? (R+1)'(-d_adj) : d_adj[R:0];
    glitch = 18'(dmag) > 18'(maxd_q);
  end

  // run counters
  logic [15:0] inv_inc, g_inc;
  assign inv_inc = (inv_run_q != 16'hFFFF) ? inv_run_q + 16'd1 : inv_run_q;
  assign g_inc   = (g_run_q != 16'hFFFF) ? g_run_q + 16'd1 : g_run_q;

  // velocity arithmetic
  logic [DivW-1:0]    prod_d;
  logic signed [31:0] rawv_d;
  logic signed [32:0] vdiff;
  logic signed [17:0] alpha_s;
  logic signed [50:0] mul_d;
  logic [50:0]        mmag;
  logic [34:0]        step_mag;
  logic signed [35:0] step_s, vsum;
  logic signed [31:0] vel_d;
  always_comb begin
    prod_d  = DivW'(dmag_q * VelScale) + DivW'(elapsed_q[15:1]);
    rawv_d  = 32'sh0;
    if (!dneg_q) begin
      rawv_d = (div_quo > DivW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
    end else begin
      rawv_d = (div_quo > DivW'(33'h0_8000_0000)) ? $signed(32'h8000_0000)
                                                  : -$signed(div_quo[31:0]);
    end
    alpha_s  = (alpha_q > AlphaOne) ? $signed({1'b0, AlphaOne}) : $signed({1'b0, alpha_q});
    vdiff    = $signed({rawv_q[31], rawv_q}) - $signed({vel_q[31], vel_q});
    mul_d    = vdiff * alpha_s;
    mmag     = mul_q[50] ? 51'(-mul_q) : 51'(mul_q);
    step_mag = 35'((mmag + 51'd32768) >> 16);
    step_s   = mul_q[50] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    vsum     = $signed({{4{vel_q[31]}}, vel_q}) + step_s;
    if (vsum > 36'sh0_7FFF_FFFF) begin
      vel_d = 32'sh7FFF_FFFF;
    end else if (vsum < -36'sh0_8000_0000) begin
      vel_d = $signed(32'h8000_0000);
    end else begin
      vel_d = vsum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_base_q <= 1'b0;
      valid_q     <= 1'b0;
      stale_q     <= 1'b0;
      last_q      <= '0;
      acc_q       <= '0;
      vel_q       <= '0;
      inv_run_q   <= '0;
      g_run_q     <= '0;
      g_cnt_q     <= '0;
    end else begin
      if (cmd_i.upd_invalid) begin
        valid_q   <= 1'b0;
        inv_run_q <= inv_inc;
        if (inv_inc >= slim_q) stale_q <= 1'b1;
      end
      if (cmd_i.div_mod) begin
        inv_run_q <= '0;
      end
      if (cmd_i.upd_base) begin
        have_base_q <= 1'b1;
        last_q      <= pos_q;
        acc_q       <= TURN_BITS'(pos_q);
        vel_q       <= '0;
        valid_q     <= 1'b1;
        stale_q     <= 1'b0;
        g_run_q     <= '0;
      end
      if (cmd_i.upd_glitch) begin
        g_cnt_q <= g_cnt_q + 32'd1;
        valid_q <= 1'b0;
        g_run_q <= g_inc;
        if (g_inc >= glim_q) stale_q <= 1'b1;
      end
      if (cmd_i.upd_accept) begin
        g_run_q <= '0;
        last_q  <= pos_q;
        acc_q   <= acc_q + TURN_BITS'(d_adj);
        valid_q <= 1'b1;
        stale_q <= 1'b0;
      end
      if (cmd_i.filt_upd) begin
        vel_q <= vel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mod)    neg_q  <= pos_s[17];
    if (cmd_i.pos_fix)    pos_q  <= R'(pos_fixed);
    if (cmd_i.upd_accept) begin
      dmag_q <= dmag;
      dneg_q <= d_adj[R+1];
    end
    if (cmd_i.vmul)       prod_q <= prod_d;
    if (cmd_i.raw_store)  rawv_q <= rawv_d;
    if (cmd_i.filt_mul)   mul_q  <= mul_d;
    if (cmd_i.elec_store) elec_q <= R'(div_rem);
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      position_counts_o   <= last_q;
      electrical_counts_o <= elec_q;
      multiturn_counts_o  <= $signed(48'(acc_q));
      velocity_o          <= vel_q;
      sample_valid_o      <= valid_q;
      stale_o             <= stale_q;
      glitch_total_o      <= g_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.invalid      = !ok_q || ({1'b0, raw_q} > RawMax);
    sts_o.have_base    = have_base_q;
    sts_o.glitch       = glitch;
    sts_o.elapsed_zero = (elapsed_q == 16'd0);
    sts_o.div_busy     = div_busy;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

endmodule
`default_nettype wire

// ----- src/eat_ctrl.sv -----
`default_nettype none
module eat_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire eat_pkg::eat_sts_t sts_i,
  output eat_pkg::eat_cmd_t      cmd_o
);
  import eat_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CHECK = 12'b0000_0000_0010,
    ST_MOD   = 12'b0000_0000_0100,
    ST_DELTA = 12'b0000_0000_1000,
    ST_VMUL  = 12'b0000_0001_0000,
    ST_VDIVS = 12'b0000_0010_0000,
    ST_VDIV  = 12'b0000_0100_0000,
    ST_FMUL  = 12'b0000_1000_0000,
    ST_FUPD  = 12'b0001_0000_0000,
    ST_ELEC  = 12'b0010_0000_0000,
    ST_EWAIT = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.invalid) begin
          cmd_o.upd_invalid = 1'b1;
          state_d           = ST_ELEC;
        end else begin
          cmd_o.div_mod = 1'b1;
          state_d       = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts_i.div_busy) begin
          cmd_o.pos_fix = 1'b1;
          state_d       = ST_DELTA;
        end
      end
      ST_DELTA: begin
        if (!sts_i.have_base) begin
          cmd_o.upd_base = 1'b1;
          state_d        = ST_ELEC;
        end else if (sts_i.glitch) begin
          cmd_o.upd_glitch = 1'b1;
          state_d          = ST_ELEC;
        end else begin
          cmd_o.upd_accept = 1'b1;
          state_d          = sts_i.elapsed_zero ? ST_ELEC : ST_VMUL;
        end
      end
      ST_VMUL: begin
        cmd_o.vmul = 1'b1;
        state_d    = ST_VDIVS;
      end
      ST_VDIVS: begin
        cmd_o.div_vel = 1'b1;
        state_d       = ST_VDIV;
      end
      ST_VDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.raw_store = 1'b1;
          state_d         = ST_FMUL;
        end
      end
      ST_FMUL: begin
        cmd_o.filt_mul = 1'b1;
        state_d        = ST_FUPD;
      end
      ST_FUPD: begin
        cmd_o.filt_upd = 1'b1;
        state_d        = ST_ELEC;
      end
      ST_ELEC: begin
        cmd_o.div_elec = 1'b1;
        state_d        = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.elec_store = 1'b1;
          state_d          = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ----- src/eat_checker.sv -----
`default_nettype none
`include "encoder_angle_tracker_assert.svh"
module eat_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [47:0]            multiturn_counts_o,
  input wire logic signed [31:0]            velocity_o,
  input wire logic                          sample_valid_o,
  input wire logic                          stale_o
);

  // a taken beat keeps the input side busy in the next cycle
  `EAT_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // an accepted sample always clears stale
  `EAT_ASSERT_IMP(a_valid_not_stale, clk_i, rst_ni, out_valid_o && sample_valid_o, !stale_o)

  `EAT_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `EAT_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                  $stable(multiturn_counts_o) && $stable(velocity_o))

endmodule

bind encoder_angle_tracker eat_checker u_eat_checker (.*);
`default_nettype wire

// ----- tb/sv/encoder_angle_tracker_tb.sv -----
`default_nettype none
module encoder_angle_tracker_tb;
  import eat_pkg::*;

  typedef struct {
    logic [15:0] code;
    logic        ok;
    logic [15:0] elapsed;
  } sample_t;

  typedef struct {
    logic [13:0]        pos;
    logic [13:0]        elec;
    logic signed [47:0] turns;
    logic signed [31:0] vel;
    logic               acc;
    logic               stale;
    logic [31:0]        glitches;
  } track_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] raw_code = '0;
  logic raw_ok = 1'b0;
  logic [15:0] elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [13:0] pos_o, elec_o;
  logic signed [47:0] turns_o;
  logic signed [31:0] vel_o;
  logic acc_o, stale_o;
  logic [31:0] glitches_o;
  logic cfg_we = 1'b0;
  eat_reg_e cfg_idx = REG_DIR;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  encoder_angle_tracker u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .raw_code_i(raw_code), .raw_ok_i(raw_ok), .elapsed_us_i(elapsed_us),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .position_counts_o(pos_o), .electrical_counts_o(elec_o),
    .multiturn_counts_o(turns_o), .velocity_o(vel_o),
    .sample_valid_o(acc_o), .stale_o(stale_o), .glitch_total_o(glitches_o),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // tracker model state and register copy
  logic        m_dir;
  logic [13:0] m_offset;
  logic [14:0] m_cpr, m_maxd;
  logic [15:0] m_stale_lim, m_gstale_lim;
  logic [16:0] m_alpha;
  logic [6:0]  m_poles;
  logic        m_base, m_acc, m_stale;
  logic [13:0] m_last;
  logic [47:0] m_turns;
  longint      m_vel;
  logic [15:0] m_inv_run, m_gl_run;
  logic [31:0] m_glitches;

  sample_t pending_q[$];
  track_t  expected_q[$];
  int errors = 0;
  bit hold_rx = 1'b0;
  int tx_gap_max = 3;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic track_t track_sample(sample_t s);
    track_t r;
    longint cpr, p, d, mag, rawv, a;
    cpr = m_cpr == 0 ? 1 : (m_cpr > 16384 ? 16384 : longint'(m_cpr));
    if (!s.ok || s.code > 16'h3FFF) begin
      m_acc = 1'b0;
      if (m_inv_run != 16'hFFFF) m_inv_run++;
      if (m_inv_run >= m_stale_lim) m_stale = 1'b1;
    end else begin
      m_inv_run = '0;
      p = longint'(s.code) - longint'(m_offset);
      if (m_dir) p = -p;
      p = p % cpr;
      if (p < 0) p += cpr;
      if (!m_base) begin
        m_base = 1'b1; m_last = p[13:0]; m_turns = p[47:0]; m_vel = 0;
        m_acc = 1'b1; m_stale = 1'b0; m_gl_run = '0;
      end else begin
        d = p - longint'(m_last);
        if (2 * d > cpr) d -= cpr;
        else if (2 * d < -cpr) d += cpr;
        mag = d < 0 ? -d : d;
        if (mag > longint'(m_maxd)) begin
          m_glitches++;
          m_acc = 1'b0;
          if (m_gl_run != 16'hFFFF) m_gl_run++;
          if (m_gl_run >= m_gstale_lim) m_stale = 1'b1;
        end else begin
          m_gl_run = '0;
          m_last = p[13:0];
          m_turns = m_turns + d[47:0];
          if (s.elapsed != 0) begin
            rawv = sat32(round_div(d * 256000000, longint'(s.elapsed)));
            a = m_alpha > 65536 ? 65536 : longint'(m_alpha);
            m_vel = sat32(m_vel + round_div(a * (rawv - m_vel), 65536));
          end
          m_acc = 1'b1; m_stale = 1'b0;
        end
      end
    end
    r.pos = m_last;
    r.elec = 14'((longint'(m_last) * longint'(m_poles)) % cpr);
    r.turns = m_turns;
    r.vel = m_vel[31:0];
    r.acc = m_acc;
    r.stale = m_stale;
    r.glitches = m_glitches;
    return r;
  endfunction

  function automatic int pick_gap(int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, long_max);
  endfunction

  // driver
  int tx_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(track_sample('{raw_code, raw_ok, elapsed_us}));
      end
      if (in_valid && in_stall) begin
      end else if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_q.size() > 0) begin
        sample_t s;
        s = pending_q.pop_front();
        in_valid <= 1'b1;
        raw_code <= s.code; raw_ok <= s.ok; elapsed_us <= s.elapsed;
        tx_wait <= tx_gap_max == 0 ? 0 : pick_gap(tx_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int rx_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat pos=%0d", $realtime, pos_o);
          errors++;
        end else begin
          track_t e;
          e = expected_q.pop_front();
          if (e.pos !== pos_o)
            $display("%0t: position exp %0d got %0d", $realtime, e.pos, pos_o);
          if (e.elec !== elec_o)
            $display("%0t: electrical exp %0d got %0d", $realtime, e.elec, elec_o);
          if (e.turns !== turns_o)
            $display("%0t: multiturn exp %0d got %0d", $realtime, e.turns, turns_o);
          if (e.vel !== vel_o)
            $display("%0t: velocity exp %0d got %0d", $realtime, e.vel, vel_o);
          if (e.acc !== acc_o)
            $display("%0t: sample_valid exp %0b got %0b", $realtime, e.acc, acc_o);
          if (e.stale !== stale_o)
            $display("%0t: stale exp %0b got %0b", $realtime, e.stale, stale_o);
          if (e.glitches !== glitches_o)
            $display("%0t: glitch_total exp %0d got %0d", $realtime, e.glitches,
                     glitches_o);
          if (e.pos !== pos_o || e.elec !== elec_o || e.turns !== turns_o ||
              e.vel !== vel_o || e.acc !== acc_o || e.stale !== stale_o ||
              e.glitches !== glitches_o) errors++;
        end
      end
      if (hold_rx) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait <= rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
        rx_wait <= tx_gap_max == 0 ? 0 : pick_gap(30);
      end
    end
  end

  task automatic write_reg(eat_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DIR:    m_dir = val[0];
      REG_OFFSET: m_offset = val[13:0];
      REG_CPR:    m_cpr = val[14:0];
      REG_MAXD:   m_maxd = val[14:0];
      REG_STALE:  m_stale_lim = val[15:0];
      REG_GSTALE: m_gstale_lim = val[15:0];
      REG_ALPHA:  m_alpha = val[16:0];
      default:    m_poles = val[6:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic push(logic [15:0] c, logic ok, logic [15:0] el);
    pending_q.push_back('{c, ok, el});
  endtask

  // mostly smooth motion with random steps, some glitches and invalid beats
  task automatic motion(int n, int span);
    int r;
    logic [15:0] c;
    c = $urandom_range(0, 16383);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) push($urandom, $urandom_range(0, 1), $urandom);
      else if (r < 13) push($urandom_range(0, 16383), 1'b1, $urandom);
      else begin
        c = 16'((int'(c) + $urandom_range(0, 2 * span) - span + 16384) % 16384);
        push(c, 1'b1, $urandom_range(0, 99) < 10 ? 16'(0) :
             ($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2000))));
      end
    end
  endtask

  initial begin
    m_dir = 0; m_offset = RstOffset; m_cpr = RstCpr; m_maxd = RstMaxD;
    m_stale_lim = RstStale; m_gstale_lim = RstGStale; m_alpha = RstAlpha;
    m_poles = RstPoles;
    m_base = 0; m_acc = 0; m_stale = 0; m_last = '0; m_turns = '0; m_vel = 0;
    m_inv_run = '0; m_gl_run = '0; m_glitches = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: before baseline, first sample, half turn, glitches, extremes
    push(16'h0000, 1'b0, 16'd100);
    push(16'h4000, 1'b1, 16'd100);
    push(16'hFFFF, 1'b1, 16'hFFFF);
    push(16'd16383, 1'b1, 16'd0);
    push(16'd0, 1'b1, 16'd1);
    push(16'd8191, 1'b1, 16'd1);
    push(16'd16383, 1'b1, 16'hFFFF);
    push(16'd8191, 1'b1, 16'd1000);
    push(16'd100, 1'b1, 16'd1);
    push(16'd8292, 1'b1, 16'd1);
    push(16'd8293, 1'b1, 16'd0);
    for (int i = 0; i < 9; i++) push(16'h7FFF, 1'b0, 16'd5);
    push(16'd8300, 1'b1, 16'd3);
    drain();

    write_reg(REG_MAXD, 15'd100);
    write_reg(REG_GSTALE, 16'd0);
    write_reg(REG_STALE, 16'd0);
    write_reg(REG_ALPHA, 17'd65536);
    push(16'd8400, 1'b1, 16'd1);
    push(16'd1000, 1'b1, 16'd1);
    push(16'd8000, 1'b0, 16'd1);
    push(16'd8350, 1'b1, 16'd1);
    drain();

    // long receiver hold while the sender keeps offering
    hold_rx = 1'b1;
    motion(20, 50);
    fork
      begin
        int k;
        k = 0;
        while (k < 400) begin @(posedge clk); k++; end
      end
    join
    hold_rx = 1'b0;
    drain();

    // varied register settings, the extremes among them
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DIR, 1); write_reg(REG_OFFSET, 14'd16383);
          write_reg(REG_CPR, 15'd1); write_reg(REG_POLES, 7'd64);
        end
        1: begin
          write_reg(REG_CPR, 15'd16384); write_reg(REG_MAXD, 15'd16384);
          write_reg(REG_ALPHA, 17'd0); write_reg(REG_POLES, 7'd1);
        end
        2: begin
          write_reg(REG_CPR, 15'd0); write_reg(REG_ALPHA, 17'h1FFFF);
          write_reg(REG_POLES, 7'd0); write_reg(REG_DIR, 0);
        end
        3: begin
          write_reg(REG_CPR, 15'h7FFF); write_reg(REG_MAXD, 15'h7FFF);
          write_reg(REG_STALE, 16'hFFFF); write_reg(REG_GSTALE, 16'hFFFF);
        end
        default: begin
          write_reg(REG_DIR, $urandom_range(0, 1));
          write_reg(REG_OFFSET, $urandom_range(0, 16383));
          write_reg(REG_CPR, $urandom_range(1, 16384));
          write_reg(REG_MAXD, $urandom_range(0, 1) ? 15'($urandom_range(0, 16384))
                                                    : 15'($urandom_range(50, 600)));
          write_reg(REG_STALE, $urandom_range(0, 12));
          write_reg(REG_GSTALE, $urandom_range(0, 12));
          write_reg(REG_ALPHA, $urandom_range(0, 65536));
          write_reg(REG_POLES, $urandom_range(0, 127));
        end
      endcase
      tx_gap_max = (ph == 5) ? 0 : 20;
      motion(ph == 3 ? 40 : 75, ph < 4 ? 16384 : 200);
      drain();
    end
    tx_gap_max = 20;

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
